FILE: hw/rtl/mtt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtt_pkg
// Shared types, tables and helpers for the melody token to tone decoder.
// ----------------------------------------------------------------------------
package mtt_pkg;

  localparam int CharW   = 8;
  localparam int CountW  = 13;
  localparam int PeriodW = 16;
  localparam int DurW    = 9;
  localparam int BeatW   = 9;
  localparam int OctW    = 3;
  localparam int TdataW  = 32;

  localparam logic [DurW-1:0] DotStep = DurW'(128);

  typedef enum logic [2:0] {
    PH_DUR    = 3'd0,
    PH_LETTER = 3'd1,
    PH_SHARP  = 3'd2,
    PH_DOT1   = 3'd3,
    PH_OCT    = 3'd4,
    PH_DOT2   = 3'd5,
    PH_TERM   = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    HD_NONE  = 2'd0,
    HD_ONE   = 2'd1,
    HD_THREE = 2'd2
  } held_t;

  typedef struct packed {
    logic             valid;
    logic [CharW-1:0] ch;
  } in_item_t;

  typedef struct packed {
    logic [PeriodW-1:0] period_preload;
    logic [BeatW-1:0]   beat_count;
    logic               note_playing;
    logic               song_end;
  } result_t;

  function automatic logic [CountW-1:0] pick_natural(input logic [CharW-1:0] ch,
                                                     input logic [CountW-1:0] keep);
    logic [CountW-1:0] v;
    v = keep;
    unique case (ch)
      "a":     v = CountW'(4545);
      "b":     v = CountW'(4048);
      "c":     v = CountW'(3824);
      "d":     v = CountW'(3407);
      "e":     v = CountW'(3035);
      "f":     v = CountW'(2865);
      "g":     v = CountW'(2551);
      "p":     v = '0;
      default: v = keep;
    endcase
    return v;
  endfunction

  function automatic logic [CountW-1:0] pick_sharp(input logic [CharW-1:0] ch,
                                                   input logic [CountW-1:0] keep);
    logic [CountW-1:0] v;
    v = keep;
    unique case (ch)
      "a":     v = CountW'(4292);
      "c":     v = CountW'(3610);
      "d":     v = CountW'(3215);
      "f":     v = CountW'(2703);
      "g":     v = CountW'(2410);
      default: v = keep;
    endcase
    return v;
  endfunction

  // 255 / d, with 255 for d of zero
  function automatic logic [7:0] beat_base(input logic [6:0] d);
    logic [7:0] q;
    q = 8'd255;
    unique case (d)
      7'd0:  q = 8'd255;
      7'd1:  q = 8'd255;
      7'd2:  q = 8'd127;
      7'd3:  q = 8'd85;
      7'd4:  q = 8'd63;
      7'd5:  q = 8'd51;
      7'd6:  q = 8'd42;
      7'd7:  q = 8'd36;
      7'd8:  q = 8'd31;
      7'd9:  q = 8'd28;
      7'd10: q = 8'd25;
      7'd11: q = 8'd23;
      7'd12: q = 8'd21;
      7'd13: q = 8'd19;
      7'd14: q = 8'd18;
      7'd15: q = 8'd17;
      7'd16: q = 8'd15;
      7'd17: q = 8'd15;
      7'd18: q = 8'd14;
      7'd19: q = 8'd13;
      7'd20: q = 8'd12;
      7'd21: q = 8'd12;
      7'd22: q = 8'd11;
      7'd23: q = 8'd11;
      7'd24: q = 8'd10;
      7'd25: q = 8'd10;
      7'd26: q = 8'd9;
      7'd27: q = 8'd9;
      7'd28: q = 8'd9;
      7'd29: q = 8'd8;
      7'd30: q = 8'd8;
      7'd31: q = 8'd8;
      7'd32: q = 8'd7;
      default: begin
        if (d <= 7'd36) q = 8'd7;
        else if (d <= 7'd42) q = 8'd6;
        else if (d <= 7'd51) q = 8'd5;
        else if (d <= 7'd63) q = 8'd4;
        else if (d <= 7'd85) q = 8'd3;
        else q = 8'd2;
      end
    endcase
    return q;
  endfunction

endpackage

FILE: hw/rtl/mtt_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtt_in_stage
// Input register for incoming characters.
// ----------------------------------------------------------------------------
module mtt_in_stage (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [mtt_pkg::CharW-1:0] s_tdata,  // [7:0] melody_char
  input  logic                     advance,
  output mtt_pkg::in_item_t        item
);

  logic                      valid;
  logic [mtt_pkg::CharW-1:0] ch;

  assign s_tready = !valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_tready) begin
      valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      ch <= s_tdata;
    end
  end

  assign item.valid = valid;
  assign item.ch    = ch;

endmodule

FILE: hw/rtl/mtt_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtt_parser
// Token state and single-pass decode of one character per cycle while the result register is free.
// ----------------------------------------------------------------------------
module mtt_parser (
  input  logic              clk,
  input  logic              rst,
  input  mtt_pkg::in_item_t item,
  input  logic              out_free,
  output logic              advance,
  output logic              emit,
  output mtt_pkg::result_t  result
);

  mtt_pkg::phase_t              phase, phase_next;
  mtt_pkg::held_t               held_digit, held_digit_next;
  logic [mtt_pkg::CharW-1:0]    held_letter, held_letter_next;
  logic [mtt_pkg::CountW-1:0]   base_count, base_count_next;
  logic [mtt_pkg::DurW-1:0]     duration_code, duration_code_next;
  logic [mtt_pkg::OctW-1:0]     octave, octave_next;
  logic [mtt_pkg::CountW-1:0]   shifted_count, shifted_count_next;
  logic                         done;
  logic [7:0]                   beat_raw;
  logic [mtt_pkg::BeatW-1:0]    beat;
  logic [mtt_pkg::CharW-1:0]    c;

  assign advance = item.valid && out_free;
  assign c       = item.ch;

  always_comb begin
    phase_next         = phase;
    held_digit_next    = held_digit;
    held_letter_next   = held_letter;
    base_count_next    = base_count;
    duration_code_next = duration_code;
    octave_next        = octave;
    shifted_count_next = shifted_count;
    done               = 1'b0;
    emit               = 1'b0;

    // unused phase code acts as the duration phase
    if (phase_next == mtt_pkg::PH_DUR || phase_next > mtt_pkg::PH_TERM) begin
      phase_next = mtt_pkg::PH_DUR;
      unique case (held_digit)
        mtt_pkg::HD_ONE: begin
          held_digit_next = mtt_pkg::HD_NONE;
          phase_next      = mtt_pkg::PH_LETTER;
          if (c == "6") begin
            duration_code_next = mtt_pkg::DurW'(16);
            done               = 1'b1;
          end else begin
            duration_code_next = mtt_pkg::DurW'(1);
          end
        end
        mtt_pkg::HD_THREE: begin
          held_digit_next = mtt_pkg::HD_NONE;
          if (c == "2") begin
            duration_code_next = mtt_pkg::DurW'(32);
            phase_next         = mtt_pkg::PH_LETTER;
            done               = 1'b1;
          end else begin
            duration_code_next = mtt_pkg::DurW'(4);
            held_letter_next   = "3";
            phase_next         = mtt_pkg::PH_SHARP;
          end
        end
        default: begin
          held_digit_next = mtt_pkg::HD_NONE;
          if (c == "3") begin
            held_digit_next = mtt_pkg::HD_THREE;
            done            = 1'b1;
          end else if (c == "1") begin
            held_digit_next = mtt_pkg::HD_ONE;
            done            = 1'b1;
          end else begin
            phase_next = mtt_pkg::PH_LETTER;
            if (c == "8" || c == "4" || c == "2") begin
              duration_code_next = mtt_pkg::DurW'(c[3:0]);
              done               = 1'b1;
            end else begin
              duration_code_next = mtt_pkg::DurW'(4);
            end
          end
        end
      endcase
    end

    if (!done && phase_next == mtt_pkg::PH_LETTER) begin
      held_letter_next = c;
      phase_next       = mtt_pkg::PH_SHARP;
      done             = 1'b1;
    end

    if (!done && phase_next == mtt_pkg::PH_SHARP) begin
      phase_next = mtt_pkg::PH_DOT1;
      if (c == "#") begin
        base_count_next = mtt_pkg::pick_sharp(held_letter_next, base_count_next);
        done            = 1'b1;
      end else begin
        base_count_next = mtt_pkg::pick_natural(held_letter_next, base_count_next);
      end
    end

    if (!done && phase_next == mtt_pkg::PH_DOT1) begin
      phase_next = mtt_pkg::PH_OCT;
      if (c == ".") begin
        duration_code_next = duration_code_next + mtt_pkg::DotStep;
        done               = 1'b1;
      end
    end

    if (!done && phase_next == mtt_pkg::PH_OCT) begin
      phase_next = mtt_pkg::PH_DOT2;
      if (c >= "4" && c <= "7") begin
        octave_next = c[2:0];
        done        = 1'b1;
      end
    end

    if (!done && phase_next == mtt_pkg::PH_DOT2) begin
      phase_next = mtt_pkg::PH_TERM;
      if (c == ".") begin
        duration_code_next = duration_code_next + mtt_pkg::DotStep;
        done               = 1'b1;
      end
    end

    if (!done && phase_next == mtt_pkg::PH_TERM) begin
      unique case (octave_next)
        3'd4:    shifted_count_next = base_count_next;
        3'd5:    shifted_count_next = base_count_next >> 1;
        3'd6:    shifted_count_next = base_count_next >> 2;
        3'd7:    shifted_count_next = base_count_next >> 3;
        default: shifted_count_next = shifted_count;
      endcase
      phase_next = mtt_pkg::PH_DUR;
      emit       = 1'b1;
    end
  end

  assign beat_raw = mtt_pkg::beat_base(duration_code_next[6:0]);
  assign beat     = duration_code_next[7]
                  ? ({1'b0, beat_raw} + {2'b00, beat_raw[7:1]})
                  : {1'b0, beat_raw};

  always_comb begin
    result.note_playing   = (shifted_count_next != '0);
    result.period_preload = result.note_playing
                          ? ~{{(mtt_pkg::PeriodW-mtt_pkg::CountW){1'b0}}, shifted_count_next}
                          : '0;
    result.beat_count     = beat;
    result.song_end       = (c != ",");
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= mtt_pkg::PH_DUR;
      held_digit    <= mtt_pkg::HD_NONE;
      held_letter   <= '0;
      base_count    <= '0;
      duration_code <= '0;
      octave        <= '0;
      shifted_count <= '0;
    end else if (advance) begin
      phase         <= phase_next;
      held_digit    <= held_digit_next;
      held_letter   <= held_letter_next;
      base_count    <= base_count_next;
      duration_code <= duration_code_next;
      octave        <= octave_next;
      shifted_count <= shifted_count_next;
    end
  end

`ifndef ASSERT_OFF
  a_emit_restarts: assert property (@(posedge clk) disable iff (rst)
    advance && emit |=> phase == mtt_pkg::PH_DUR)
    else $error("phase not back to duration after a result");

  a_held_in_dur: assert property (@(posedge clk) disable iff (rst)
    held_digit != mtt_pkg::HD_NONE |-> phase == mtt_pkg::PH_DUR)
    else $error("digit held outside duration phase");

  a_beat_range: assert property (@(posedge clk) disable iff (rst)
    advance && emit |-> result.beat_count <= mtt_pkg::BeatW'(382))
    else $error("beat count out of range");
`endif

endmodule

FILE: hw/rtl/mtt_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtt_out_stage
// Result register driving the output stream.
// ----------------------------------------------------------------------------
module mtt_out_stage (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        load,
  input  mtt_pkg::result_t            result,
  output logic                        out_free,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [mtt_pkg::TdataW-1:0]  m_tdata,  // [15:0] period_preload, [24:16] beat_count
  output logic                        m_tlast,  // song_end
  output logic                        m_tuser   // note_playing
);

  logic             valid;
  mtt_pkg::result_t data;

  assign out_free = !valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (out_free) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && load) begin
      data <= result;
    end
  end

  assign m_tvalid = valid;
  assign m_tdata  = {{(mtt_pkg::TdataW-mtt_pkg::PeriodW-mtt_pkg::BeatW){1'b0}},
                     data.beat_count, data.period_preload};
  assign m_tlast  = data.song_end;
  assign m_tuser  = data.note_playing;

endmodule

FILE: hw/rtl/melody_token_to_tone_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// melody_token_to_tone_top
// Decodes melody text, one character per item, into tone and beat items.
// ----------------------------------------------------------------------------
// input stream s_*: one ascii character per item in s_tdata[7:0]
// output stream m_*: one item per token terminator
//   m_tdata[15:0] period_preload, m_tdata[24:16] beat_count
//   m_tuser note_playing, m_tlast song_end
// characters other than a terminator give no output item
// path: a terminator passes the input register, then is decoded into the result
//   register, and shows on m_tvalid from there
// throughput: one character per cycle while no result waits on m_tready, with the
//   decode done combinationally between the input register and the result register
// reset: rst clears the valid flags of both registers and the token state
//   to the start of a token with no duration digit held, octave and counts at zero
// stall: while a result waits with m_tready low, the character in the
//   input register waits and s_tready drops once that register is full
// ----------------------------------------------------------------------------
module melody_token_to_tone_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [mtt_pkg::CharW-1:0]   s_tdata,  // [7:0] melody_char
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [mtt_pkg::TdataW-1:0]  m_tdata,  // [15:0] period_preload, [24:16] beat_count
  output logic                        m_tlast,  // song_end
  output logic                        m_tuser   // note_playing
);

  mtt_pkg::in_item_t item;
  mtt_pkg::result_t  result;
  logic              advance;
  logic              emit;
  logic              out_free;

  mtt_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .advance  (advance),
    .item     (item)
  );

  mtt_parser u_parser (
    .clk      (clk),
    .rst      (rst),
    .item     (item),
    .out_free (out_free),
    .advance  (advance),
    .emit     (emit),
    .result   (result)
  );

  mtt_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (advance && emit),
    .result   (result),
    .out_free (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule
